### hw/rtl/fmr_pkg.sv
// Package for the fraction multiply/reduce block: shared constants and the
// sequencer state type. No dependencies.
package fmr_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;
  localparam int RESULT_WIDTH      = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_N,
    ST_MUL_D,
    ST_GCD_CHK,
    ST_GCD_DIV,
    ST_DIV_N,
    ST_DIV_D,
    ST_DONE
  } fmr_state_t;

endpackage

### hw/rtl/fmr_in_if.sv
// Operand channel of the fraction multiply/reduce block: valid/ready plus the
// two fractions. Depends on nothing.
interface fmr_in_if #(parameter int OPERAND_WIDTH = 16);
  logic                            valid;
  logic                            ready;
  logic signed [OPERAND_WIDTH-1:0] num_a;
  logic signed [OPERAND_WIDTH-1:0] den_a;
  logic signed [OPERAND_WIDTH-1:0] num_b;
  logic signed [OPERAND_WIDTH-1:0] den_b;

  modport source (output valid, num_a, den_a, num_b, den_b, input ready);
  modport sink   (input valid, num_a, den_a, num_b, den_b, output ready);
endinterface

### hw/rtl/fmr_out_if.sv
// Result channel of the fraction multiply/reduce block: valid/ready plus the
// reduced fraction and the error flag. Uses fmr_pkg for the result width.
interface fmr_out_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [fmr_pkg::RESULT_WIDTH-1:0] prod_num;
  logic signed [fmr_pkg::RESULT_WIDTH-1:0] prod_den;
  logic                                    zero_den_error;

  modport source (output valid, prod_num, prod_den, zero_den_error, input ready);
  modport sink   (input valid, prod_num, prod_den, zero_den_error, output ready);
endinterface

### hw/rtl/fraction_multiply_reduce_top.sv
// Sequence: multiply the numerators, then the denominators; then one or more Euclid
// remainder steps, each a check and a division; a final check; the two quotient
// divisions (numerator, then denominator); and the load of the result register.
// A zero denominator skips straight to the load. One word in flight; the next word
// is taken the cycle after the result is registered, even while that result waits.
// The one bit-per-cycle divider is shared. Reset (synchronous, rst high) idles and empties the result register.
module fraction_multiply_reduce_top #(
  parameter int OPERAND_WIDTH = fmr_pkg::OPERAND_WIDTH_DEF
) (
  input logic    clk,
  input logic    rst,
  fmr_in_if.sink operands,
  fmr_out_if.source result
);
  import fmr_pkg::*;

  localparam int PW = 2 * OPERAND_WIDTH;              // full product width
  localparam int CW = $clog2(PW);                     // divider step counter width
  localparam int XW = (PW > RESULT_WIDTH) ? PW : RESULT_WIDTH;

  typedef struct packed {
    logic in_ready;
    logic out_load;
    logic div_step;
    logic div_last;
  } fmr_ctrl_t;

  fmr_state_t state, state_next;
  fmr_ctrl_t  ctrl;

  // latched operands
  logic signed [OPERAND_WIDTH-1:0] num_a, den_a, num_b, den_b;
  logic                            zero_den;

  // product magnitudes and signs
  logic [PW-1:0] pn_mag, pd_mag;
  logic          pn_neg, pd_neg;

  // Euclid pair; a ends up as the gcd
  logic [PW-1:0] a, b;

  // shared restoring divider
  logic [PW-1:0] rem, quo;
  logic [CW-1:0] cnt;
  logic [PW-1:0] divisor;
  logic [PW:0]   rem_sh;
  logic          rem_ge;
  logic [PW-1:0] rem_new, quo_new;

  // reduced magnitudes
  logic [PW-1:0] qn;

  // shared multiplier
  logic signed [OPERAND_WIDTH-1:0] mul_x, mul_y;
  logic signed [PW-1:0]            mul_p;
  logic [PW-1:0]                   mul_mag;

  // output formatting
  logic signed [PW-1:0] sn, sd;
  logic signed [XW-1:0] xn, xd;

  logic in_fire;
  logic den_is_zero;

  assign in_fire     = operands.valid && ctrl.in_ready;
  assign den_is_zero = (operands.den_a == '0) || (operands.den_b == '0);

  // numerator product first, then denominator product
  assign mul_x   = (state == ST_MUL_N) ? num_a : den_a;
  assign mul_y   = (state == ST_MUL_N) ? num_b : den_b;
  assign mul_p   = mul_x * mul_y;
  assign mul_mag = mul_p[PW-1] ? PW'(-mul_p) : PW'(mul_p);

  // one quotient bit per cycle
  assign divisor = (state == ST_GCD_DIV) ? b : a;
  assign rem_sh  = {rem, quo[PW-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor};
  assign rem_new = rem_ge ? PW'(rem_sh - {1'b0, divisor}) : rem_sh[PW-1:0];
  assign quo_new = {quo[PW-2:0], rem_ge};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) state_next = den_is_zero ? ST_DONE : ST_MUL_N;
      end
      ST_MUL_N:   state_next = ST_MUL_D;
      ST_MUL_D:   state_next = ST_GCD_CHK;
      ST_GCD_CHK: state_next = (b == '0) ? ST_DIV_N : ST_GCD_DIV;
      ST_GCD_DIV: begin
        if (ctrl.div_last) state_next = ST_GCD_CHK;
      end
      ST_DIV_N: begin
        if (ctrl.div_last) state_next = ST_DIV_D;
      end
      ST_DIV_D: begin
        if (ctrl.div_last) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (ctrl.out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.in_ready = (state == ST_IDLE);
    ctrl.out_load = (state == ST_DONE) && (!result.valid || result.ready);
    case (state)
      ST_GCD_DIV, ST_DIV_N, ST_DIV_D: ctrl.div_step = 1'b1;
      default:                        ctrl.div_step = 1'b0;
    endcase
    ctrl.div_last = ctrl.div_step && (cnt == CW'(PW - 1));
  end

  assign operands.ready = ctrl.in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      num_a    <= operands.num_a;
      den_a    <= operands.den_a;
      num_b    <= operands.num_b;
      den_b    <= operands.den_b;
      zero_den <= den_is_zero;
    end
    if (state == ST_MUL_N) begin
      pn_mag <= mul_mag;
      pn_neg <= mul_p[PW-1];
      a      <= mul_mag;
    end
    if (state == ST_MUL_D) begin
      pd_mag <= mul_mag;
      pd_neg <= mul_p[PW-1];
      b      <= mul_mag;
    end
    if (state == ST_GCD_CHK) begin
      // load a dividend: a % b while b is nonzero, else the numerator quotient
      rem <= '0;
      cnt <= '0;
      quo <= (b == '0) ? pn_mag : a;
    end else if (ctrl.div_step) begin
      if (ctrl.div_last && (state == ST_DIV_N)) begin
        // numerator quotient done; start on the denominator
        qn  <= quo_new;
        rem <= '0;
        cnt <= '0;
        quo <= pd_mag;
      end else begin
        rem <= rem_new;
        quo <= quo_new;
        cnt <= cnt + CW'(1);
      end
      if (ctrl.div_last && (state == ST_GCD_DIV)) begin
        a <= b;
        b <= rem_new;
      end
    end
  end

  // reapply signs; quo holds the denominator quotient in ST_DONE
  assign sn = pn_neg ? -$signed(qn) : $signed(qn);
  assign sd = pd_neg ? -$signed(quo) : $signed(quo);
  assign xn = XW'(sn);
  assign xd = XW'(sd);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (ctrl.out_load) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      result.zero_den_error <= zero_den;
      result.prod_num       <= zero_den ? '0 : xn[RESULT_WIDTH-1:0];
      result.prod_den       <= zero_den ? '0 : xd[RESULT_WIDTH-1:0];
    end
  end

endmodule

### hw/rtl/fmr_checker.sv
// Port-level checks for fraction_multiply_reduce_top, bound to the top level.
// Uses fmr_pkg for the result width.
module fmr_checker (
  input logic                                    clk,
  input logic                                    rst,
  input logic                                    in_valid,
  input logic                                    in_ready,
  input logic                                    out_valid,
  input logic                                    out_ready,
  input logic signed [fmr_pkg::RESULT_WIDTH-1:0] prod_num,
  input logic signed [fmr_pkg::RESULT_WIDTH-1:0] prod_den,
  input logic                                    zero_den_error
);
  import fmr_pkg::*;

  // one word at a time: taking a word closes the operand side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("operand side still open after a word was taken");

  // error words carry a zero fraction
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_den_error |-> (prod_num == '0) && (prod_den == '0))
    else $error("error word with nonzero fraction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(prod_num) && $stable(prod_den)
                                && $stable(zero_den_error))
    else $error("result changed while stalled");

endmodule

bind fraction_multiply_reduce_top fmr_checker u_fmr_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (operands.valid),
  .in_ready       (operands.ready),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .prod_num       (result.prod_num),
  .prod_den       (result.prod_den),
  .zero_den_error (result.zero_den_error)
);
